// ===== hw/rtl/gpdf_pkg.sv =====
`timescale 1ns / 1ps
// gpdf_pkg: widths, register map and interpolation table of the gauge pointer
// damping filter. No dependencies.

package gpdf_pkg;

    localparam int TARGET_W  = 16;
    localparam int POS_W     = 16;
    localparam int CD_W      = 8;
    localparam int FB_W      = 8;
    localparam int SH_W      = 3;
    localparam int STAGE_W   = 22;
    localparam int FRAC_BITS = 4;
    localparam int LP_IN_W   = STAGE_W + 1;
    localparam int F_W       = LP_IN_W - FRAC_BITS;

    // position / 10 as a reciprocal multiply, exact over 16-bit values
    localparam int DIV10_SHIFT = 19;
    localparam logic [POS_W-1:0] DIV10_MUL = 16'd52429;
    localparam int P_W = 2 * POS_W - DIV10_SHIFT;

    localparam int TABLE_POINTS = 9;
    localparam int X_W  = 10;
    localparam int Y_W  = 8;
    localparam int DX_W = 7;
    localparam int DY_W = 5;
    localparam int NUM_W = DX_W + DY_W;
    localparam int QB_W  = $clog2(DY_W);

    localparam logic [X_W-1:0] TBL_X [TABLE_POINTS] = '{
        10'd0, 10'd112, 10'd225, 10'd337, 10'd450, 10'd562, 10'd675, 10'd787, 10'd900
    };
    localparam logic [Y_W-1:0] TBL_Y [TABLE_POINTS] = '{
        8'd0, 8'd25, 8'd54, 8'd75, 8'd101, 8'd125, 8'd147, 8'd175, 8'd196
    };

    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int RIDX_W = 3;

    localparam logic [RIDX_W-1:0] REG_DEADBAND        = 3'd0;
    localparam logic [RIDX_W-1:0] REG_MAX_STEP        = 3'd1;
    localparam logic [RIDX_W-1:0] REG_FIRST_SHIFT     = 3'd2;
    localparam logic [RIDX_W-1:0] REG_SECOND_SHIFT    = 3'd3;
    localparam logic [RIDX_W-1:0] REG_UPDATE_INTERVAL = 3'd4;
    localparam logic [RIDX_W-1:0] REG_FINE_BAND       = 3'd5;

    localparam int OUT_DATA_W = 24;

endpackage

// ===== hw/rtl/gauge_pointer_damping_filter.sv =====
`timescale 1ns / 1ps
// A skipped tick runs only divide by ten and table search; an update tick also runs hysteresis and,
// when the held target leaves the fine band, the filter passes and step clamp. Output stalls add.
// Throughput: one tick at a time; the next is accepted in the cycle after the result is loaded.
// The sequencer steps through hysteresis, two passes of the shared low-pass unit, step clamp,
// divide by ten, table search and a 5-step shift-subtract divider. Depends on gpdf_pkg.
// Reset (rst_n, async, low): registers to defaults, filter state and position to zero.

module gauge_pointer_damping_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gpdf_pkg::TARGET_W-1:0]      s_tdata,   // [15:0] target_value
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gpdf_pkg::OUT_DATA_W-1:0]    m_tdata,   // [15:0] position, [23:16] image_index
    output logic                               m_tuser,   // [0] updated
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gpdf_pkg::ADDR_W-1:0]        paddr,
    input  logic [gpdf_pkg::DATA_W-1:0]        pwdata,
    output logic [gpdf_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import gpdf_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_HOLD  = 9'b000000010,
        ST_LP1   = 9'b000000100,
        ST_LP2   = 9'b000001000,
        ST_STEP  = 9'b000010000,
        ST_DIV10 = 9'b000100000,
        ST_SEG   = 9'b001000000,
        ST_DIVQ  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    localparam int HALF      = (1 << FRAC_BITS) >> 1;
    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;

    state_t state_reg, state_next;

    logic [TARGET_W-1:0] deadband_reg, deadband_next;
    logic [POS_W-1:0]    max_step_reg, max_step_next;
    logic [SH_W-1:0]     first_shift_reg, first_shift_next;
    logic [SH_W-1:0]     second_shift_reg, second_shift_next;
    logic [CD_W-1:0]     interval_reg, interval_next;
    logic [FB_W-1:0]     fine_band_reg, fine_band_next;

    logic [CD_W-1:0]     countdown_reg, countdown_next;
    logic [TARGET_W-1:0] held_reg, held_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [STAGE_W-1:0]  s1_reg, s1_next;
    logic [STAGE_W-1:0]  s2_reg, s2_next;
    logic [Y_W-1:0]      img_reg, img_next;

    logic [TARGET_W-1:0] target_reg, target_next;
    logic                upd_reg, upd_next;
    logic [P_W-1:0]      p_reg, p_next;
    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [DX_W-1:0]     dvs_reg, dvs_next;
    logic [Y_W-1:0]      base_reg, base_next;
    logic [DY_W-1:0]     q_reg, q_next;
    logic [QB_W-1:0]     bit_reg, bit_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                  cfg_wr;
    logic [RIDX_W-1:0]     cfg_idx;

    // shared low-pass unit
    logic [LP_IN_W-1:0]  lp_din;
    logic [STAGE_W-1:0]  lp_acc;
    logic [SH_W-1:0]     lp_sh;
    logic [STAGE_W-1:0]  lp_out;

    function automatic logic [STAGE_W-1:0] lowpass(
        input logic [LP_IN_W-1:0] din,
        input logic [STAGE_W-1:0] acc,
        input logic [SH_W-1:0]    sh
    );
        logic [LP_IN_W:0] acc_x;
        logic [LP_IN_W:0] din_x;
        logic [LP_IN_W:0] diff;
        logic [LP_IN_W:0] comp;
        logic [LP_IN_W:0] sum;
        acc_x = (LP_IN_W+1)'(acc);
        din_x = (LP_IN_W+1)'(din);
        comp  = ((LP_IN_W+1)'(1) << sh) - (LP_IN_W+1)'(1);
        if (din_x > acc_x)
        begin
            diff = din_x - acc_x;
            sum  = (diff >> sh) + acc_x + comp;
        end
        else
        begin
            diff = acc_x - din_x;
            sum  = acc_x - (diff >> sh);
        end
        return sum[STAGE_W-1:0];
    endfunction

    function automatic logic [LP_IN_W-1:0] round_whole(input logic [STAGE_W-1:0] v);
        logic [LP_IN_W-1:0] tmp;
        tmp = LP_IN_W'(v) + LP_IN_W'(HALF);
        return tmp & ~LP_IN_W'(FRAC_MASK);
    endfunction

    assign lp_din = state_reg == ST_LP1 ? (LP_IN_W'(held_reg) << FRAC_BITS)
                                        : round_whole(s1_reg);
    assign lp_acc = state_reg == ST_LP1 ? s1_reg : s2_reg;
    assign lp_sh  = state_reg == ST_LP1 ? first_shift_reg : second_shift_reg;
    assign lp_out = lowpass(lp_din, lp_acc, lp_sh);

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_DEADBAND:        prdata = DATA_W'(deadband_reg);
            REG_MAX_STEP:        prdata = DATA_W'(max_step_reg);
            REG_FIRST_SHIFT:     prdata = DATA_W'(first_shift_reg);
            REG_SECOND_SHIFT:    prdata = DATA_W'(second_shift_reg);
            REG_UPDATE_INTERVAL: prdata = DATA_W'(interval_reg);
            REG_FINE_BAND:       prdata = DATA_W'(fine_band_reg);
            default:             prdata = '0;
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // hysteresis and band terms
    logic [TARGET_W:0]        t_sum;
    logic [TARGET_W:0]        db17;
    logic                     cond_a, cond_b, cond_c, cond_d;
    logic signed [TARGET_W+1:0] ht_s, db_s, cp_s, fb_s, hn_s;
    logic [TARGET_W-1:0]      held_upd;
    logic                     outside;

    // step clamp terms
    logic [LP_IN_W-1:0] rnd2;
    logic [F_W-1:0]     f_val, pos_x, mag, dlt;
    logic               rising;
    logic [POS_W-1:0]   dlt16, pos_upd;

    // divide by ten and table search
    logic [2*POS_W-1:0] prod10;
    logic               hit_exact, hit_seg;
    logic [Y_W-1:0]     y_exact, y0_c;
    logic [X_W-1:0]     x0_c;
    logic [DX_W-1:0]    dx_c;
    logic [DY_W-1:0]    dy_c;
    logic [DX_W-1:0]    off_c;
    logic [NUM_W-1:0]   sub_c;
    logic               ge_c;
    logic [DY_W-1:0]    q_bit;

    always_comb
    begin
        t_sum  = (TARGET_W+1)'(target_reg) + (TARGET_W+1)'(fine_band_reg);
        db17   = (TARGET_W+1)'(deadband_reg);
        ht_s   = $signed((TARGET_W+2)'(held_reg));
        db_s   = $signed((TARGET_W+2)'(deadband_reg));
        cp_s   = $signed((TARGET_W+2)'(pos_reg));
        fb_s   = $signed((TARGET_W+2)'(fine_band_reg));
        cond_a = (t_sum - db17) > (TARGET_W+1)'(held_reg);
        cond_b = (ht_s - db_s) > cp_s;
        cond_c = ((TARGET_W+2)'(t_sum) + (TARGET_W+2)'(deadband_reg))
                 < (TARGET_W+2)'(held_reg);
        cond_d = ((TARGET_W+1)'(held_reg) + db17) < (TARGET_W+1)'(pos_reg);
        if (t_sum <= db17)
            held_upd = '0;
        else if (cond_a || cond_b || cond_c || cond_d)
            held_upd = t_sum[TARGET_W-1:0];
        else
            held_upd = held_reg;
        hn_s    = $signed((TARGET_W+2)'(held_upd));
        outside = (hn_s > cp_s + fb_s) || (hn_s < cp_s - fb_s);

        rnd2   = round_whole(s2_reg);
        f_val  = rnd2[LP_IN_W-1:FRAC_BITS];
        pos_x  = F_W'(pos_reg);
        rising = f_val >= pos_x;
        mag    = rising ? f_val - pos_x : pos_x - f_val;
        if (mag > F_W'(max_step_reg))
            dlt = F_W'(max_step_reg);
        else if (mag < F_W'(fine_band_reg))
            dlt = F_W'(fine_band_reg);
        else
            dlt = mag;
        dlt16 = dlt[POS_W-1:0];
        if (rising)
            pos_upd = pos_reg + dlt16;
        else if (pos_reg > dlt16)
            pos_upd = pos_reg - dlt16;
        else
            pos_upd = '0;

        prod10 = (2*POS_W)'(pos_reg) * (2*POS_W)'(DIV10_MUL);

        hit_exact = 1'b0;
        hit_seg   = 1'b0;
        y_exact   = '0;
        x0_c      = '0;
        y0_c      = '0;
        dx_c      = '0;
        dy_c      = '0;
        for (int i = 0; i < TABLE_POINTS; i++)
        begin
            if (p_reg == P_W'(TBL_X[i]))
            begin
                hit_exact = 1'b1;
                y_exact   = TBL_Y[i];
            end
        end
        for (int i = 0; i < TABLE_POINTS - 1; i++)
        begin
            if (p_reg > P_W'(TBL_X[i]) && p_reg < P_W'(TBL_X[i+1]))
            begin
                hit_seg = 1'b1;
                x0_c    = TBL_X[i];
                y0_c    = TBL_Y[i];
                dx_c    = DX_W'(TBL_X[i+1] - TBL_X[i]);
                dy_c    = DY_W'(TBL_Y[i+1] - TBL_Y[i]);
            end
        end
        off_c = DX_W'(p_reg - P_W'(x0_c));

        sub_c = NUM_W'(dvs_reg) << bit_reg;
        ge_c  = rem_reg >= sub_c;
        q_bit = ge_c ? (DY_W'(1) << bit_reg) : '0;
    end

    always_comb
    begin
        state_next        = state_reg;
        deadband_next     = deadband_reg;
        max_step_next     = max_step_reg;
        first_shift_next  = first_shift_reg;
        second_shift_next = second_shift_reg;
        interval_next     = interval_reg;
        fine_band_next    = fine_band_reg;
        countdown_next    = countdown_reg;
        held_next         = held_reg;
        pos_next          = pos_reg;
        s1_next           = s1_reg;
        s2_next           = s2_reg;
        img_next          = img_reg;
        target_next       = target_reg;
        upd_next          = upd_reg;
        p_next            = p_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        base_next         = base_reg;
        q_next            = q_reg;
        bit_next          = bit_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DEADBAND:        deadband_next     = pwdata[TARGET_W-1:0];
                REG_MAX_STEP:        max_step_next     = pwdata[POS_W-1:0];
                REG_FIRST_SHIFT:     first_shift_next  = pwdata[SH_W-1:0];
                REG_SECOND_SHIFT:    second_shift_next = pwdata[SH_W-1:0];
                REG_UPDATE_INTERVAL: interval_next     = pwdata[CD_W-1:0];
                REG_FINE_BAND:       fine_band_next    = pwdata[FB_W-1:0];
                default:             ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    target_next = s_tdata;
                    if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - CD_W'(1);
                        upd_next       = 1'b0;
                        state_next     = ST_DIV10;
                    end
                    else
                    begin
                        countdown_next = interval_reg;
                        upd_next       = 1'b1;
                        state_next     = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                held_next  = held_upd;
                state_next = outside ? ST_LP1 : ST_DIV10;
            end
            ST_LP1:
            begin
                s1_next    = lp_out;
                state_next = ST_LP2;
            end
            ST_LP2:
            begin
                s2_next    = lp_out;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                pos_next   = pos_upd;
                state_next = ST_DIV10;
            end
            ST_DIV10:
            begin
                p_next     = prod10[2*POS_W-1:DIV10_SHIFT];
                state_next = ST_SEG;
            end
            ST_SEG:
            begin
                if (hit_exact)
                begin
                    img_next   = y_exact;
                    state_next = ST_DONE;
                end
                else if (hit_seg)
                begin
                    rem_next   = NUM_W'(off_c) * NUM_W'(dy_c);
                    dvs_next   = dx_c;
                    base_next  = y0_c;
                    q_next     = '0;
                    bit_next   = QB_W'(DY_W - 1);
                    state_next = ST_DIVQ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVQ:
            begin
                if (ge_c)
                    rem_next = rem_reg - sub_c;
                q_next = q_reg | q_bit;
                if (bit_reg == '0)
                begin
                    img_next   = base_reg + Y_W'(q_reg | q_bit);
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next = bit_reg - QB_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {img_reg, pos_reg};
                    m_tuser_next  = upd_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            deadband_reg     <= '0;
            max_step_reg     <= POS_W'(100);
            first_shift_reg  <= SH_W'(2);
            second_shift_reg <= SH_W'(2);
            interval_reg     <= '0;
            fine_band_reg    <= '0;
            countdown_reg    <= '0;
            held_reg         <= '0;
            pos_reg          <= '0;
            s1_reg           <= '0;
            s2_reg           <= '0;
            img_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            deadband_reg     <= deadband_next;
            max_step_reg     <= max_step_next;
            first_shift_reg  <= first_shift_next;
            second_shift_reg <= second_shift_next;
            interval_reg     <= interval_next;
            fine_band_reg    <= fine_band_next;
            countdown_reg    <= countdown_next;
            held_reg         <= held_next;
            pos_reg          <= pos_next;
            s1_reg           <= s1_next;
            s2_reg           <= s2_next;
            img_reg          <= img_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg  <= target_next;
        upd_reg     <= upd_next;
        p_reg       <= p_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        base_reg    <= base_next;
        q_reg       <= q_next;
        bit_reg     <= bit_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef NO_ASSERTIONS
    a_countdown_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && countdown_reg != '0)
        |=> (countdown_reg == $past(countdown_reg) - CD_W'(1)))
        else $error("tick countdown did not decrement on a skipped tick");

    a_pos_only_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_STEP) |=> $stable(pos_reg))
        else $error("position changed outside the step state");

    a_stage_only_in_lp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LP1 && state_reg != ST_LP2) |=> ($stable(s1_reg) && $stable(s2_reg)))
        else $error("low-pass state changed outside the filter passes");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVQ)
        |-> ((NUM_W+1)'(rem_reg) < (((NUM_W+1)'(dvs_reg) << bit_reg) << 1)))
        else $error("divider remainder out of range");
`endif

endmodule
